// ===== rtl/slle_pkg.sv =====
// shared types and constants for the static linked list engine
// used by slle_ctrl, slle_dp and static_linked_list_engine_core; no dependencies
`default_nettype none

package slle_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned NODE_W  = 6;
  localparam int unsigned PTR_W   = 7;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned TDATA_W = 40;

  // null marker for head and next links
  localparam logic [PTR_W-1:0] NIL = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR     = 3'd0,
    FN_INS_HEAD  = 3'd1,
    FN_INS_AFTER = 3'd2,
    FN_REM_AFTER = 3'd3,
    FN_REM_HEAD  = 3'd4,
    FN_TRAVERSE  = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NO_SUCC   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  // where the node field of an emitted word comes from
  typedef enum logic [1:0] {
    EM_NONE  = 2'd0,
    EM_ALLOC = 2'd1,
    EM_NEW   = 2'd2,
    EM_WALK  = 2'd3
  } emit_src_t;

  typedef struct packed {
    logic      capture;
    logic      rd_follow;
    logic      clear_list;
    logic      alloc_head;
    logic      alloc_after;
    logic      link_new;
    logic      link_skip;
    logic      head_pop;
    logic      walk_start;
    logic      walk_step;
    logic      emit;
    emit_src_t src;
    status_t   code;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  k_bad;
    logic  full;
    logic  succ_bad;
    logic  head_bad;
    logic  walk_end;
    logic  out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/static_linked_list_engine_core.sv =====
// top level of the static linked list engine
// depends on slle_pkg, slle_ctrl and slle_dp
`default_nettype none

// Array-backed singly linked list of up to DEPTH nodes with a bump allocator.
// Each input word is one operation, selected by s_tuser: clear, insert at head,
// insert after node k, remove the successor of k, remove head, or traverse.
// Every operation answers with one output word carrying a status in m_tuser,
// except a traverse of a non-empty list, which sends one word per node from
// head to tail with m_tlast on the final one. Clear, insert at head, remove
// head and every error case end in the execute state; insert-after and
// remove-after go on to a link or skip state, as the link memory has a single
// write port (and remove-after needs a second dependent read). A traverse
// sends one node per cycle unless the output stalls: the registered read of
// the link memory follows each link. Removed nodes are not reclaimed until a
// clear. Output backpressure stalls each step; a new word is accepted while
// the last answer still waits in the output register. No clearing pass after reset.
module static_linked_list_engine_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [5:0] node_index, [37:6] value_in, [39:38] zero
  input  wire logic [slle_pkg::TDATA_W-1:0]  s_tdata,
  // [2:0] func
  input  wire logic [slle_pkg::FUNC_W-1:0]   s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [31:0] value_out, [37:32] node_out, [39:38] zero
  output logic [slle_pkg::TDATA_W-1:0]       m_tdata,
  // [2:0] status
  output logic [slle_pkg::STAT_W-1:0]        m_tuser,
  output logic                               m_tlast
);

  slle_pkg::cmd_t    cmd;
  slle_pkg::dp_sts_t sts;

  slle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // one operation at a time: the cycle after an accept the input side is closed
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an operation is in progress");

  // the controller never overwrites a word that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("output word overwritten");

  // allocation only happens with room left in the pool
  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc_head || cmd.alloc_after) |-> !sts.full)
    else $error("allocation with a full pool");

endmodule

`default_nettype wire

// ===== rtl/slle_ctrl.sv =====
// controller state machine for the linked list engine
// depends on slle_pkg; drives slle_dp through cmd_t and reads dp_sts_t
`default_nettype none

module slle_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire slle_pkg::dp_sts_t sts,
  output slle_pkg::cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_LINK = 5'b00100,
    S_SKIP = 5'b01000,
    S_WALK = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          case (sts.func)
            slle_pkg::FN_CLEAR: begin
              cmd.clear_list = 1'b1;
              cmd.emit       = 1'b1;
              cmd.code       = slle_pkg::ST_OK;
            end
            slle_pkg::FN_INS_HEAD: begin
              cmd.emit = 1'b1;
              if (sts.full) begin
                cmd.code = slle_pkg::ST_FULL;
              end else begin
                cmd.alloc_head = 1'b1;
                cmd.src        = slle_pkg::EM_ALLOC;
                cmd.code       = slle_pkg::ST_OK;
              end
            end
            slle_pkg::FN_INS_AFTER: begin
              if (sts.k_bad) begin
                cmd.emit = 1'b1;
                cmd.code = slle_pkg::ST_BAD_INDEX;
              end else if (sts.full) begin
                cmd.emit = 1'b1;
                cmd.code = slle_pkg::ST_FULL;
              end else begin
                cmd.alloc_after = 1'b1;
                state_next      = S_LINK;
              end
            end
            slle_pkg::FN_REM_AFTER: begin
              if (sts.k_bad) begin
                cmd.emit = 1'b1;
                cmd.code = slle_pkg::ST_BAD_INDEX;
              end else if (sts.succ_bad) begin
                cmd.emit = 1'b1;
                cmd.code = slle_pkg::ST_NO_SUCC;
              end else begin
                // fetch the successor's link
                cmd.rd_follow = 1'b1;
                state_next    = S_SKIP;
              end
            end
            slle_pkg::FN_REM_HEAD: begin
              cmd.emit = 1'b1;
              if (sts.head_bad) begin
                cmd.code = slle_pkg::ST_EMPTY;
              end else begin
                cmd.head_pop = 1'b1;
                cmd.code     = slle_pkg::ST_OK;
              end
            end
            slle_pkg::FN_TRAVERSE: begin
              if (sts.head_bad) begin
                cmd.emit = 1'b1;
                cmd.code = slle_pkg::ST_EMPTY;
              end else begin
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
              end
            end
            default: begin
              cmd.emit = 1'b1;
              cmd.code = slle_pkg::ST_BAD_INDEX;
            end
          endcase
        end
      end
      S_LINK: begin
        if (sts.out_free) begin
          cmd.link_new = 1'b1;
          cmd.emit     = 1'b1;
          cmd.src      = slle_pkg::EM_NEW;
          cmd.code     = slle_pkg::ST_OK;
          state_next   = S_IDLE;
        end
      end
      S_SKIP: begin
        if (sts.out_free) begin
          cmd.link_skip = 1'b1;
          cmd.emit      = 1'b1;
          cmd.code      = slle_pkg::ST_OK;
          state_next    = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = slle_pkg::EM_WALK;
          cmd.code = slle_pkg::ST_OK;
          if (sts.walk_end) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_step = 1'b1;
            cmd.rd_follow = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slle_dp.sv =====
// datapath: value and link memories, head pointer, allocator, walk cursor, output register
// depends on slle_pkg; commanded by slle_ctrl
`default_nettype none

module slle_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [slle_pkg::TDATA_W-1:0]  s_tdata,
  input  wire logic [slle_pkg::FUNC_W-1:0]   s_tuser,
  input  wire slle_pkg::cmd_t                cmd,
  output slle_pkg::dp_sts_t                  sts,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [slle_pkg::TDATA_W-1:0]       m_tdata,
  output logic [slle_pkg::STAT_W-1:0]        m_tuser,
  output logic                               m_tlast
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [slle_pkg::PTR_W-1:0] DEPTH_P = slle_pkg::PTR_W'(DEPTH);

  logic [slle_pkg::VAL_W-1:0]  value_mem [DEPTH];
  logic [slle_pkg::PTR_W-1:0]  next_mem  [DEPTH];

  logic [slle_pkg::FUNC_W-1:0] func_r;
  logic [slle_pkg::NODE_W-1:0] k_r;
  logic [slle_pkg::VAL_W-1:0]  val_r;
  logic [slle_pkg::PTR_W-1:0]  head;
  logic [slle_pkg::PTR_W-1:0]  alloc_count;
  logic [slle_pkg::NODE_W-1:0] new_node;
  logic [slle_pkg::NODE_W-1:0] cur;
  logic [slle_pkg::PTR_W-1:0]  cnt;
  logic [slle_pkg::VAL_W-1:0]  rd_value;
  logic [slle_pkg::PTR_W-1:0]  rd_next;

  logic [slle_pkg::NODE_W-1:0] in_k;
  logic [slle_pkg::VAL_W-1:0]  in_val;
  slle_pkg::func_t             in_func;

  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        val_we;
  logic                        nx_we;
  logic [AW-1:0]               wr_addr;
  logic [slle_pkg::PTR_W-1:0]  wr_next;

  logic [slle_pkg::NODE_W-1:0] node_o;
  logic [slle_pkg::VAL_W-1:0]  value_o;
  logic                        last_o;

  assign in_k    = s_tdata[slle_pkg::NODE_W-1:0];
  assign in_val  = s_tdata[slle_pkg::NODE_W +: slle_pkg::VAL_W];
  assign in_func = slle_pkg::func_t'(s_tuser);

  // read port: on accept it looks at node k or the head, later it follows a link
  always_comb begin
    rd_en = cmd.capture | cmd.rd_follow;
    if (cmd.rd_follow) begin
      rd_addr = rd_next[AW-1:0];
    end else if (in_func == slle_pkg::FN_INS_AFTER || in_func == slle_pkg::FN_REM_AFTER) begin
      rd_addr = in_k[AW-1:0];
    end else begin
      rd_addr = head[AW-1:0];
    end
  end

  // write port: new node at the allocator, or a relink of node k
  always_comb begin
    val_we  = cmd.alloc_head | cmd.alloc_after;
    nx_we   = val_we | cmd.link_new | cmd.link_skip;
    wr_addr = alloc_count[AW-1:0];
    wr_next = rd_next;
    if (cmd.alloc_head) begin
      wr_next = head;
    end else if (cmd.link_new) begin
      wr_addr = k_r[AW-1:0];
      wr_next = {1'b0, new_node};
    end else if (cmd.link_skip) begin
      wr_addr = k_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[wr_addr] <= val_r;
    end
    if (nx_we) begin
      next_mem[wr_addr] <= wr_next;
    end
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      rd_next  <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= s_tuser;
      k_r    <= in_k;
      val_r  <= in_val;
    end
    if (cmd.alloc_after) begin
      new_node <= alloc_count[slle_pkg::NODE_W-1:0];
    end
    if (cmd.walk_start) begin
      cur <= head[slle_pkg::NODE_W-1:0];
      cnt <= slle_pkg::PTR_W'(1);
    end else if (cmd.walk_step) begin
      cur <= rd_next[slle_pkg::NODE_W-1:0];
      cnt <= cnt + slle_pkg::PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= slle_pkg::NIL;
      alloc_count <= '0;
    end else begin
      if (cmd.clear_list) begin
        head        <= slle_pkg::NIL;
        alloc_count <= '0;
      end else begin
        if (cmd.alloc_head) begin
          head <= alloc_count;
        end else if (cmd.head_pop) begin
          head <= rd_next;
        end
        if (cmd.alloc_head || cmd.alloc_after) begin
          alloc_count <= alloc_count + slle_pkg::PTR_W'(1);
        end
      end
    end
  end

  // node indices are valid only below the allocator, so the null marker fails too
  always_comb begin
    sts.func     = slle_pkg::func_t'(func_r);
    sts.k_bad    = ({1'b0, k_r} >= alloc_count);
    sts.full     = (alloc_count >= DEPTH_P);
    sts.succ_bad = (rd_next >= alloc_count);
    sts.head_bad = (head >= alloc_count);
    sts.walk_end = (rd_next >= alloc_count) || (cnt == DEPTH_P);
    sts.out_free = ~m_tvalid | m_tready;
  end

  always_comb begin
    value_o = '0;
    last_o  = 1'b1;
    case (cmd.src)
      slle_pkg::EM_ALLOC: node_o = alloc_count[slle_pkg::NODE_W-1:0];
      slle_pkg::EM_NEW:   node_o = new_node;
      slle_pkg::EM_WALK: begin
        node_o  = cur;
        value_o = rd_value;
        last_o  = sts.walk_end;
      end
      default:            node_o = '0;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {2'b00, node_o, value_o};
      m_tuser <= cmd.code;
      m_tlast <= last_o;
    end
  end

endmodule

`default_nettype wire
